// ===== rtl/sparse_column_variance_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the sparse column variance block.
// Both macros sample on clk_i and are disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef SPARSE_COLUMN_VARIANCE_MACROS_SVH
`define SPARSE_COLUMN_VARIANCE_MACROS_SVH

// General property check.
`define SCV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Same-cycle implication check.
`define SCV_ASSERT_IMP(lbl, ante, cons, msg) \
  `SCV_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// ===== rtl/scv_pkg.sv =====
// ---------------------------------------------------------------------------
// scv_pkg
// Shared widths, register indexes, operation codes and control types of the
// sparse column variance block.
// ---------------------------------------------------------------------------
`default_nettype none

package scv_pkg;

  localparam int unsigned MAX_ROWS_DEF   = 65536;
  localparam int unsigned VALUE_BITS_DEF = 24;

  localparam int unsigned VAL_W  = 24;  // input value field
  localparam int unsigned CNT_W  = 17;  // row and entry counts
  localparam int unsigned SUM_W  = 40;  // signed sum of values
  localparam int unsigned SQ_W   = 63;  // sum of squares
  localparam int unsigned ITEM_SQ_W = 2 * VAL_W - 1;  // one squared value
  localparam int unsigned MAG_W  = 40;  // magnitude of the sum
  localparam int unsigned PROD_W = 80;  // numerator and unit accumulator
  localparam int unsigned DIV_W  = 33;  // divisor n*(n-1)
  localparam int unsigned VAR_W  = 48;  // variance result
  localparam int unsigned STEP_W = 7;   // unit step counter
  localparam int unsigned DATA_W = 32;  // configuration data
  localparam int unsigned ADDR_W = 3;   // configuration address

  localparam logic [CNT_W-1:0] ROWS_RESET = 17'h10000;

  // Register index, taken from paddr[2].
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_SKIP = 1'b1;

  typedef enum logic [1:0] {
    OP_MUL_NEW,  // clear accumulator, then shift-add multiply
    OP_MUL_SUB,  // keep accumulator, shift-subtract multiply
    OP_DIV       // restoring divide of the accumulator
  } op_e;

  typedef struct packed {
    logic              start;
    op_e               op;
    logic [STEP_W-1:0] steps;
  } ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } stat_t;

endpackage

`default_nettype wire

// ===== rtl/scv_unit.sv =====
// ---------------------------------------------------------------------------
// scv_unit
// Shared arithmetic unit: one wide adder used one bit per cycle, either as a
// shift-add (or shift-subtract) multiplier or as a restoring divider.
// ---------------------------------------------------------------------------
`default_nettype none

module scv_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire scv_pkg::ctrl_t               ctrl_i,
  input  wire logic [scv_pkg::PROD_W-1:0]   mcand_i,
  input  wire logic [scv_pkg::MAG_W-1:0]    mplier_i,
  input  wire logic [scv_pkg::DIV_W-1:0]    divisor_i,
  output scv_pkg::stat_t                    stat_o,
  output logic [scv_pkg::PROD_W-1:0]        result_o
);

  localparam int unsigned PW = scv_pkg::PROD_W;
  localparam int unsigned DW = scv_pkg::DIV_W;

  logic                          busy_q, done_q;
  scv_pkg::op_e                  op_q;
  logic [scv_pkg::STEP_W-1:0]    cnt_q;
  logic [PW-1:0]                 acc_q, mcand_q;
  logic [scv_pkg::MAG_W-1:0]     mplier_q;
  logic [DW-1:0]                 div_q, rem_q;

  logic [DW:0]                   rem_shift;
  logic [PW-1:0]                 add_x, add_y;
  logic                          add_sub;
  logic [PW:0]                   add_sum;
  logic                          q_bit;
  logic                          last_step;

  assign rem_shift = {rem_q, acc_q[PW-1]};
  assign last_step = busy_q && (cnt_q == scv_pkg::STEP_W'(1));

  // The single shared adder. On subtract, the carry out is set when x >= y.
  always_comb begin
    case (op_q)
      scv_pkg::OP_MUL_SUB: begin
        add_x   = acc_q;
        add_y   = mcand_q;
        add_sub = 1'b1;
      end
      scv_pkg::OP_DIV: begin
        add_x   = PW'(rem_shift);
        add_y   = PW'(div_q);
        add_sub = 1'b1;
      end
      default: begin
        add_x   = acc_q;
        add_y   = mcand_q;
        add_sub = 1'b0;
      end
    endcase
    add_sum = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)} + (PW+1)'(add_sub);
  end

  assign q_bit = add_sum[PW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= scv_pkg::OP_MUL_NEW;
      cnt_q  <= '0;
    end else begin
      done_q <= last_step;
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        op_q   <= ctrl_i.op;
        cnt_q  <= ctrl_i.steps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - scv_pkg::STEP_W'(1);
        if (last_step) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      mcand_q  <= mcand_i;
      mplier_q <= mplier_i;
      div_q    <= divisor_i;
      rem_q    <= '0;
      if (ctrl_i.op == scv_pkg::OP_MUL_NEW) begin
        acc_q <= '0;
      end
    end else if (busy_q) begin
      case (op_q)
        scv_pkg::OP_DIV: begin
          acc_q <= {acc_q[PW-2:0], q_bit};
          rem_q <= q_bit ? add_sum[DW-1:0] : rem_shift[DW-1:0];
        end
        default: begin
          if (mplier_q[0]) begin
            acc_q <= add_sum[PW-1:0];
          end
          mcand_q  <= {mcand_q[PW-2:0], 1'b0};
          mplier_q <= {1'b0, mplier_q[scv_pkg::MAG_W-1:1]};
        end
      endcase
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign result_o    = acc_q;

endmodule

`default_nettype wire

// ===== rtl/sparse_column_variance.sv =====
// ---------------------------------------------------------------------------
// sparse_column_variance: sample variance of one sparse column, streamed.
// Each entry item is folded into the sums before the next item is taken; a closing
// item with a defined result runs the shared add/subtract unit for the divisor, the
// product n*S2, the subtraction of S1*S1 and the divide, in that order.
// Reset is asynchronous and active low; it clears all sums and counters.
// ---------------------------------------------------------------------------
`default_nettype none
`include "sparse_column_variance_macros.svh"

module sparse_column_variance #(
  parameter int unsigned MAX_ROWS   = scv_pkg::MAX_ROWS_DEF,
  parameter int unsigned VALUE_BITS = scv_pkg::VALUE_BITS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,

  // Configuration port. pready is tied high, so no access is extended
  // by wait states.
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [scv_pkg::ADDR_W-1:0]        paddr,
  input  wire logic [scv_pkg::DATA_W-1:0]        pwdata,
  output logic [scv_pkg::DATA_W-1:0]             prdata,
  output logic                                   pready,

  // Entry stream.
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic signed [scv_pkg::VAL_W-1:0]  value_i,
  input  wire logic                              is_missing_i,
  input  wire logic                              has_value_i,
  input  wire logic                              last_i,

  // Result stream, one transfer per column.
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [scv_pkg::VAR_W-1:0]              variance_o,
  output logic                                   undefined_o
);

  localparam int unsigned CW = scv_pkg::CNT_W;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE  = 3'd0;  // take the next item
  localparam logic [2:0] ST_ACC   = 3'd1;  // fold the item into the sums
  localparam logic [2:0] ST_EVAL  = 3'd2;  // work out n and the undefined flag
  localparam logic [2:0] ST_MULD  = 3'd3;  // divisor n*(n-1)
  localparam logic [2:0] ST_MULP1 = 3'd4;  // n * sum of squares
  localparam logic [2:0] ST_MULP2 = 3'd5;  // subtract sum * sum
  localparam logic [2:0] ST_DIV   = 3'd6;  // divide the numerator
  localparam logic [2:0] ST_DONE  = 3'd7;  // hand the result to the output

  localparam logic [CW-1:0] MaxRowsC = CW'(MAX_ROWS);

  logic [2:0] state_q, state_d;

  // Configuration registers.
  logic [CW-1:0] rows_q;
  logic          skip_q;
  logic          cfg_write;

  // Captured item.
  logic signed [scv_pkg::VAL_W-1:0]     v_ext;
  logic signed [2*scv_pkg::VAL_W-1:0]   v_square;
  logic signed [scv_pkg::VAL_W-1:0]     v_q;
  logic [scv_pkg::ITEM_SQ_W-1:0]        sq_q;
  logic                                 item_miss_q, item_has_q, item_last_q;
  logic                                 in_accept;

  // Column state.
  logic signed [scv_pkg::SUM_W-1:0]     sum_q;
  logic [scv_pkg::SQ_W-1:0]             sq_sum_q;
  logic [CW-1:0]                        entry_q, miss_q;
  logic [CW-1:0]                        total;

  // Evaluation.
  logic [CW-1:0]                        rows_eff, n_d, n_q;
  logic                                 undef_d;
  logic [scv_pkg::MAG_W-1:0]            mag;
  logic [scv_pkg::DIV_W-1:0]            d_q;
  logic [scv_pkg::VAR_W-1:0]            var_q;
  logic                                 undef_q;

  // Output register.
  logic                                 out_valid_q;
  logic [scv_pkg::VAR_W-1:0]            out_var_q;
  logic                                 out_undef_q;
  logic                                 out_load;

  // Shared unit.
  scv_pkg::ctrl_t                       unit_ctrl;
  scv_pkg::stat_t                       unit_stat;
  logic [scv_pkg::PROD_W-1:0]           unit_mcand, unit_result;
  logic [scv_pkg::MAG_W-1:0]            unit_mplier;

  // -------------------------------------------------------------------------
  // Configuration port. Bit 2 of the address selects the register.
  // -------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= scv_pkg::ROWS_RESET;
      skip_q <= 1'b0;
    end else if (cfg_write) begin
      case (paddr[2])
        scv_pkg::REG_ROWS: rows_q <= pwdata[CW-1:0];
        scv_pkg::REG_SKIP: skip_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      scv_pkg::REG_ROWS: prdata = scv_pkg::DATA_W'(rows_q);
      scv_pkg::REG_SKIP: prdata = scv_pkg::DATA_W'(skip_q);
      default:           prdata = '0;
    endcase
  end

  // -------------------------------------------------------------------------
  // Input side. Only the low VALUE_BITS bits of the value carry data; they
  // are sign extended to the full field. The square is registered at
  // acceptance and summed in the following cycle.
  // -------------------------------------------------------------------------
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    for (int i = 0; i < scv_pkg::VAL_W; i++) begin
      v_ext[i] = (i < VALUE_BITS) ? value_i[i] : value_i[VALUE_BITS-1];
    end
  end

  assign v_square = v_ext * v_ext;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      v_q         <= v_ext;
      sq_q        <= v_square[scv_pkg::ITEM_SQ_W-1:0];
      item_miss_q <= is_missing_i;
      item_has_q  <= has_value_i;
      item_last_q <= last_i;
    end
  end

  // -------------------------------------------------------------------------
  // Column evaluation. The effective row count is clamped to MAX_ROWS. With
  // skip_missing set, missing entries leave the sample; without it, any
  // missing entry makes the result undefined. More stored entries than rows,
  // or fewer than two samples, also make it undefined.
  // -------------------------------------------------------------------------
  assign total    = entry_q + miss_q;
  assign rows_eff = (rows_q > MaxRowsC) ? MaxRowsC : rows_q;

  always_comb begin
    if (skip_q) begin
      n_d = (miss_q <= rows_eff) ? (rows_eff - miss_q) : '0;
    end else begin
      n_d = rows_eff;
    end
    undef_d = (total > rows_eff) || (!skip_q && (miss_q != '0)) || (n_d < CW'(2));
  end

  // The magnitude of the sum; the most negative sum maps to its true size.
  assign mag = sum_q[scv_pkg::SUM_W-1] ? scv_pkg::MAG_W'(-sum_q)
                                       : scv_pkg::MAG_W'(sum_q);

  // -------------------------------------------------------------------------
  // Sequencer. The variance is (n*S2 - S1*S1) / (n*(n-1)). The divisor is
  // built first and parked in d_q, so the numerator can grow in the unit's
  // accumulator and be divided in place.
  // -------------------------------------------------------------------------
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d         = state_q;
    unit_ctrl.start = 1'b0;
    unit_ctrl.op    = scv_pkg::OP_MUL_NEW;
    unit_ctrl.steps = '0;
    unit_mcand      = '0;
    unit_mplier     = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        state_d = item_last_q ? ST_EVAL : ST_IDLE;
      end
      ST_EVAL: begin
        if (undef_d) begin
          state_d = ST_DONE;
        end else begin
          unit_ctrl.start = 1'b1;
          unit_ctrl.op    = scv_pkg::OP_MUL_NEW;
          unit_ctrl.steps = scv_pkg::STEP_W'(CW);
          unit_mcand      = scv_pkg::PROD_W'(n_d - CW'(1));
          unit_mplier     = scv_pkg::MAG_W'(n_d);
          state_d         = ST_MULD;
        end
      end
      ST_MULD: begin
        if (unit_stat.done) begin
          unit_ctrl.start = 1'b1;
          unit_ctrl.op    = scv_pkg::OP_MUL_NEW;
          unit_ctrl.steps = scv_pkg::STEP_W'(CW);
          unit_mcand      = scv_pkg::PROD_W'(sq_sum_q);
          unit_mplier     = scv_pkg::MAG_W'(n_q);
          state_d         = ST_MULP1;
        end
      end
      ST_MULP1: begin
        if (unit_stat.done) begin
          unit_ctrl.start = 1'b1;
          unit_ctrl.op    = scv_pkg::OP_MUL_SUB;
          unit_ctrl.steps = scv_pkg::STEP_W'(scv_pkg::MAG_W);
          unit_mcand      = scv_pkg::PROD_W'(mag);
          unit_mplier     = mag;
          state_d         = ST_MULP2;
        end
      end
      ST_MULP2: begin
        if (unit_stat.done) begin
          unit_ctrl.start = 1'b1;
          unit_ctrl.op    = scv_pkg::OP_DIV;
          unit_ctrl.steps = scv_pkg::STEP_W'(scv_pkg::PROD_W);
          state_d         = ST_DIV;
        end
      end
      ST_DIV: begin
        if (unit_stat.done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Column sums and counters. Counting stops once the entries exceed
  // MAX_ROWS, and entries past MAX_ROWS are counted but not summed; such a
  // column is always undefined. Everything clears when the result is loaded into the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q    <= '0;
      sq_sum_q <= '0;
      entry_q  <= '0;
      miss_q   <= '0;
    end else if (out_load) begin
      sum_q    <= '0;
      sq_sum_q <= '0;
      entry_q  <= '0;
      miss_q   <= '0;
    end else if ((state_q == ST_ACC) && item_has_q && (total <= MaxRowsC)) begin
      if (item_miss_q) begin
        miss_q <= miss_q + CW'(1);
      end else begin
        if (total < MaxRowsC) begin
          sum_q    <= sum_q + scv_pkg::SUM_W'(v_q);
          sq_sum_q <= sq_sum_q + scv_pkg::SQ_W'(sq_q);
        end
        entry_q <= entry_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_EVAL) begin
      n_q     <= n_d;
      undef_q <= undef_d;
      var_q   <= '0;
    end
    if ((state_q == ST_MULD) && unit_stat.done) begin
      d_q <= unit_result[scv_pkg::DIV_W-1:0];
    end
    if ((state_q == ST_DIV) && unit_stat.done) begin
      var_q <= unit_result[scv_pkg::VAR_W-1:0];
    end
  end

  scv_unit u_unit (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (unit_ctrl),
    .mcand_i   (unit_mcand),
    .mplier_i  (unit_mplier),
    .divisor_i (d_q),
    .stat_o    (unit_stat),
    .result_o  (unit_result)
  );

  // -------------------------------------------------------------------------
  // Output register. It decouples the result from the sequencer, so the next
  // column can be taken while a finished result still waits for its transfer.
  // -------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_var_q   <= undef_q ? '0 : var_q;
      out_undef_q <= undef_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign variance_o  = out_var_q;
  assign undefined_o = out_undef_q;

  // -------------------------------------------------------------------------
  // Assertions.
  // -------------------------------------------------------------------------
  `SCV_ASSERT_IMP(a_undef_zero, out_valid_o && undefined_o, variance_o == '0,
                  "undefined result carries a nonzero variance")
  `SCV_ASSERT_IMP(a_start_idle, unit_ctrl.start, !unit_stat.busy,
                  "shared unit started while busy")
  `SCV_ASSERT_IMP(a_done_wait, unit_stat.done,
                  state_q == ST_MULD || state_q == ST_MULP1 ||
                  state_q == ST_MULP2 || state_q == ST_DIV,
                  "shared unit finished outside a waiting state")
  `SCV_ASSERT(a_count_cap,
              ({1'b0, entry_q} + {1'b0, miss_q}) <= (CW+1)'(MAX_ROWS + 1),
              "entry counters passed their cap")

endmodule

`default_nettype wire
